// ----- src/hng_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package hng_pkg;

    localparam int DEF_MAX_COLS    = 1024;
    localparam int DEF_MAX_ROWS    = 4096;
    localparam int DEF_HEIGHT_BITS = 16;
    localparam int DEF_COL_W       = $clog2(DEF_MAX_COLS);
    localparam int DEF_ROW_W       = $clog2(DEF_MAX_ROWS);

    localparam int COLS_W     = 11;
    localparam int ROWS_W     = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_COLS = 1'b0,
        REG_GRID_ROWS = 1'b1
    } t_cfg_reg;

    localparam logic [COLS_W-1:0] COLS_RST = 11'd1024;
    localparam logic [ROWS_W-1:0] ROWS_RST = 13'd1024;

    localparam int TWO_Q88     = 512;
    localparam int FRAC_BITS   = 14;
    localparam int NRM_W       = FRAC_BITS + 1;
    localparam int NRM_S_W     = FRAC_BITS + 2;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [COLS_W-1:0] cols;
        logic [ROWS_W-1:0] rows;
    } t_grid_cfg;

endpackage
`default_nettype wire

// ----- src/hng_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module hng_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [NW-1:0]    r_count;

    assign o_full  = (32'(r_count) == 32'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == 32'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == 32'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + NW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - NW'(1);
            end
        end
    end
endmodule
`default_nettype wire

// ----- src/hng_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module hng_front import hng_pkg::*; #(
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int HEIGHT_BITS = DEF_HEIGHT_BITS,
    parameter int CW          = DEF_COL_W,
    parameter int RW          = DEF_ROW_W,
    parameter int JW          = 2 * (DEF_HEIGHT_BITS + 1) + DEF_COL_W + DEF_ROW_W + 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_grid_cfg                     i_cfg,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [HEIGHT_BITS-1:0] i_height,
    output logic                               o_push,
    output logic [JW-1:0]                      o_job,
    input  wire logic                          i_full
);
    localparam int HB  = HEIGHT_BITS;
    localparam int DW  = HB + 1;
    localparam int CLW = $clog2(MAX_COLS + 1);
    localparam int RLW = $clog2(MAX_ROWS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_RD_C, S_RD_N, S_RD_M1, S_RD_M2, S_WR, S_PUSH
    } t_state;

    t_state r_state;
    logic [CW-1:0]          r_col, r_c, c0;
    logic [RW-1:0]          r_row, r_r, r0;
    logic signed [HB-1:0]   r_left, r_h, r_p_n, r_p_m2;
    logic [2*HB-1:0]        r_e_c, r_e_m1, r_rd;
    logic [2:0]             r_mask, sel;
    logic [2*HB-1:0]        r_mem [MAX_COLS];
    logic [CW-1:0]          rd_addr;
    logic                   mem_we;
    logic [CLW-1:0]         cols;
    logic [RLW-1:0]         rows;

    logic signed [HB-1:0] c_prev, c_old, m1_prev, m1_old;
    logic signed [HB-1:0] la, ra, ua, lb, ub, lc, uc;
    logic signed [DW-1:0] dxa, dza, dxb, dzb, dxc, dzc, dx_sel, dz_sel;
    logic [CW-1:0]        col_sel;
    logic [RW-1:0]        row_sel;
    logic                 at_last_row, at_last_col, wrap_col, wrap_row;

    always_comb begin
        if (i_cfg.cols == '0) begin
            cols = CLW'(1);
        end else if (32'(i_cfg.cols) > 32'(MAX_COLS)) begin
            cols = CLW'(MAX_COLS);
        end else begin
            cols = CLW'(i_cfg.cols);
        end
        if (i_cfg.rows == '0) begin
            rows = RLW'(1);
        end else if (32'(i_cfg.rows) > 32'(MAX_ROWS)) begin
            rows = RLW'(MAX_ROWS);
        end else begin
            rows = RLW'(i_cfg.rows);
        end
    end

    always_comb begin
        c0 = r_col;
        r0 = r_row;
        if (32'(r_row) >= 32'(rows)) begin
            c0 = '0;
            r0 = '0;
        end else if (32'(r_col) >= 32'(cols)) begin
            c0 = '0;
            r0 = (32'(r_row) + 1 >= 32'(rows)) ? '0 : r_row + RW'(1);
        end
    end

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        unique case (r_state)
            S_RD_N:  rd_addr = r_c + CW'(1);
            S_RD_M1: rd_addr = r_c - CW'(1);
            S_RD_M2: rd_addr = r_c - CW'(2);
            default: rd_addr = r_c;
        endcase
    end

    assign mem_we = (r_state == S_WR);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_c] <= {r_h, r_e_c[2*HB-1:HB]};
        end
        r_rd <= r_mem[rd_addr];
    end

    assign c_prev  = r_e_c[2*HB-1:HB];
    assign c_old   = r_e_c[HB-1:0];
    assign m1_prev = r_e_m1[2*HB-1:HB];
    assign m1_old  = r_e_m1[HB-1:0];

    assign at_last_row = (32'(r_r) + 1 == 32'(rows));
    assign at_last_col = (32'(r_c) + 1 == 32'(cols));
    assign wrap_col    = (32'(r_c) + 1 >= 32'(cols));
    assign wrap_row    = (32'(r_r) + 1 >= 32'(rows));

    always_comb begin
        la  = (r_c != '0) ? m1_old : c_prev;
        ra  = (32'(r_c) + 1 < 32'(cols)) ? r_p_n : c_prev;
        ua  = (32'(r_r) >= 2) ? c_old : c_prev;
        dxa = DW'(ra) - DW'(la);
        dza = DW'(r_h) - DW'(ua);
        lb  = (32'(r_c) >= 2) ? r_p_m2 : m1_prev;
        ub  = (r_r != '0) ? m1_old : m1_prev;
        dxb = DW'(r_h) - DW'(lb);
        dzb = DW'(m1_prev) - DW'(ub);
        lc  = (r_c != '0) ? r_left : r_h;
        uc  = (r_r != '0) ? c_prev : r_h;
        dxc = DW'(r_h) - DW'(lc);
        dzc = DW'(r_h) - DW'(uc);
    end

    always_comb begin
        priority if (r_mask[0]) begin
            sel = 3'b001; dx_sel = dxa; dz_sel = dza;
            col_sel = r_c; row_sel = r_r - RW'(1);
        end else if (r_mask[1]) begin
            sel = 3'b010; dx_sel = dxb; dz_sel = dzb;
            col_sel = r_c - CW'(1); row_sel = r_r;
        end else begin
            sel = r_mask; dx_sel = dxc; dz_sel = dzc;
            col_sel = r_c; row_sel = r_r;
        end
    end

    assign o_push = (r_state == S_PUSH) && (r_mask != '0) && !i_full;
    assign o_job  = {dx_sel, dz_sel, col_sel, row_sel, ((r_mask & ~sel) == '0)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_left  <= '0;
            r_mask  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_c     <= c0;
                        r_r     <= r0;
                        r_h     <= i_height;
                        r_state <= S_RD_C;
                    end
                end
                S_RD_C: r_state <= S_RD_N;
                S_RD_N: begin
                    r_e_c   <= r_rd;
                    r_state <= S_RD_M1;
                end
                S_RD_M1: begin
                    r_p_n   <= r_rd[2*HB-1:HB];
                    r_state <= S_RD_M2;
                end
                S_RD_M2: begin
                    r_e_m1  <= r_rd;
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_p_m2  <= r_rd[2*HB-1:HB];
                    r_mask  <= {at_last_row && at_last_col,
                                at_last_row && (r_c != '0),
                                (r_r != '0)};
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (r_mask == '0) begin
                        r_left <= r_h;
                        if (wrap_col) begin
                            r_col <= '0;
                            r_row <= wrap_row ? '0 : r_r + RW'(1);
                        end else begin
                            r_col <= r_c + CW'(1);
                            r_row <= r_r;
                        end
                        r_state <= S_IDLE;
                    end else if (!i_full) begin
                        r_mask <= r_mask & ~sel;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- src/hng_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module hng_back import hng_pkg::*; #(
    parameter int HEIGHT_BITS = DEF_HEIGHT_BITS,
    parameter int CW          = DEF_COL_W,
    parameter int RW          = DEF_ROW_W,
    parameter int JW          = 2 * (DEF_HEIGHT_BITS + 1) + DEF_COL_W + DEF_ROW_W + 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [JW-1:0]     i_job,
    input  wire logic              i_empty,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic signed [NRM_S_W-1:0] o_normal_x,
    output logic [NRM_W-1:0]       o_normal_y,
    output logic signed [NRM_S_W-1:0] o_normal_z,
    output logic [CW-1:0]          o_out_col,
    output logic [RW-1:0]          o_out_row,
    output logic                   o_last_of_run
);
    localparam int HB   = HEIGHT_BITS;
    localparam int DW   = HB + 1;
    localparam int SQW  = 2 * HB;
    localparam int SW   = ((SQW > 19) ? SQW : 19) + 2;
    localparam int TSH  = 2 * FRAC_BITS + 2;
    localparam int TW   = SW + TSH;
    localparam int PW   = SW + 2 * FRAC_BITS + 5;
    localparam int KW   = $clog2(TSH + 1);
    localparam int TWO2 = TWO_Q88 * TWO_Q88;

    typedef enum logic [2:0] {B_IDLE, B_SQ, B_SUM, B_ITER, B_OUT} t_state;

    t_state r_state;
    logic signed [DW-1:0] r_dx, r_dz;
    logic [CW-1:0]        r_col;
    logic [RW-1:0]        r_row;
    logic                 r_last;
    logic [SQW-1:0]       r_sqx, r_sqz;
    logic [SW-1:0]        r_s, s_next;
    logic signed [PW-1:0] r_p [3];
    logic signed [PW-1:0] r_q [3];
    logic [TW-1:0]        r_t [3];
    logic [NRM_W-1:0]     r_n [3];
    logic [KW-1:0]        r_k, sh_q, sh_s, sh_h;
    logic signed [PW-1:0] cand [3];
    logic signed [PW-1:0] s_ext;
    logic [2:0]           take;
    logic [DW-1:0]        ax, az;

    assign o_pop   = (r_state == B_IDLE) && !i_empty;
    assign o_valid = (r_state == B_OUT);

    assign ax     = r_dx[DW-1] ? DW'(-r_dx) : DW'(r_dx);
    assign az     = r_dz[DW-1] ? DW'(-r_dz) : DW'(r_dz);
    assign s_next = SW'(r_sqx) + SW'(r_sqz) + SW'(TWO2);
    assign s_ext  = $signed(PW'(r_s));
    assign sh_q   = r_k + KW'(2);
    assign sh_h   = r_k + KW'(1);
    assign sh_s   = (r_k << 1) + KW'(2);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cand[i] = r_p[i] + (r_q[i] <<< sh_q) + (s_ext <<< sh_s);
            take[i] = (cand[i] <= $signed(PW'(r_t[i])));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_dx    <= i_job[JW-1 -: DW];
                        r_dz    <= i_job[JW-DW-1 -: DW];
                        r_col   <= i_job[RW+CW:RW+1];
                        r_row   <= i_job[RW:1];
                        r_last  <= i_job[0];
                        r_state <= B_SQ;
                    end
                end
                B_SQ: begin
                    r_sqx   <= SQW'(ax[HB-1:0]) * SQW'(ax[HB-1:0]);
                    r_sqz   <= SQW'(az[HB-1:0]) * SQW'(az[HB-1:0]);
                    r_state <= B_SUM;
                end
                B_SUM: begin
                    r_s <= s_next;
                    for (int i = 0; i < 3; i++) begin
                        r_p[i] <= $signed(PW'(s_next));
                        r_q[i] <= -$signed(PW'(s_next));
                        r_n[i] <= '0;
                    end
                    r_t[0]  <= TW'(r_sqx) << TSH;
                    r_t[1]  <= TW'(TWO2) << TSH;
                    r_t[2]  <= TW'(r_sqz) << TSH;
                    r_k     <= KW'(FRAC_BITS);
                    r_state <= B_ITER;
                end
                B_ITER: begin
                    for (int i = 0; i < 3; i++) begin
                        if (take[i]) begin
                            r_p[i] <= cand[i];
                            r_q[i] <= r_q[i] + (s_ext <<< sh_h);
                            r_n[i] <= r_n[i] | (NRM_W'(1) << r_k);
                        end
                    end
                    if (r_k == '0) begin
                        r_state <= B_OUT;
                    end else begin
                        r_k <= r_k - KW'(1);
                    end
                end
                B_OUT: begin
                    if (!i_stall) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_normal_x    = r_dx[DW-1] ? $signed({1'b0, r_n[0]}) : -$signed({1'b0, r_n[0]});
    assign o_normal_y    = r_n[1];
    assign o_normal_z    = r_dz[DW-1] ? $signed({1'b0, r_n[2]}) : -$signed({1'b0, r_n[2]});
    assign o_out_col     = r_col;
    assign o_out_row     = r_row;
    assign o_last_of_run = r_last;
endmodule
`default_nettype wire

// ----- src/heightmap_normal_generator_unit.sv -----
// Channel  | Valid        | Stall        | Payload
// ---------+--------------+--------------+-------------------------------------------
// in       | i_in_valid   | o_in_stall   | i_height
// out      | o_out_valid  | i_out_stall  | o_normal_x/y/z, o_out_col, o_out_row,
//          |              |              | o_last_of_run
// config   | i_cfg_we     | none         | i_cfg_idx, i_cfg_data
//
// Front end takes one height at a time: one accept step, five line-buffer port
// steps on the single-port row memory, one push per normal, one to retire.
// Back end, one job at a time: pop, square, sum, 15 search steps, output.
// Synchronous active-low reset clears counters, queue and both FSMs; row memory is
// not cleared. A stalled output holds the back end; a full queue holds the front end.
`timescale 1ns / 1ps
`default_nettype none
module heightmap_normal_generator_unit import hng_pkg::*; #(
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int HEIGHT_BITS = DEF_HEIGHT_BITS,
    parameter int CW          = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    parameter int RW          = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic signed [HEIGHT_BITS-1:0] i_height,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [NRM_S_W-1:0]          o_normal_x,
    output logic [NRM_W-1:0]                   o_normal_y,
    output logic signed [NRM_S_W-1:0]          o_normal_z,
    output logic [CW-1:0]                      o_out_col,
    output logic [RW-1:0]                      o_out_row,
    output logic                               o_last_of_run
);
    localparam int JW = 2 * (HEIGHT_BITS + 1) + CW + RW + 1;

    t_grid_cfg r_cfg;
    logic          push, full, pop, empty;
    logic [JW-1:0] job_in, job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cols <= COLS_RST;
            r_cfg.rows <= ROWS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_GRID_COLS: r_cfg.cols <= i_cfg_data[COLS_W-1:0];
                REG_GRID_ROWS: r_cfg.rows <= i_cfg_data[ROWS_W-1:0];
                default:       r_cfg <= r_cfg;
            endcase
        end
    end

    hng_front #(
        .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .HEIGHT_BITS(HEIGHT_BITS),
        .CW(CW), .RW(RW), .JW(JW)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(i_in_valid), .o_stall(o_in_stall), .i_height(i_height),
        .o_push(push), .o_job(job_in), .i_full(full)
    );

    hng_queue #(.WIDTH(JW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data(job_in), .o_full(full),
        .i_pop(pop), .o_data(job_out), .o_empty(empty)
    );

    hng_back #(
        .HEIGHT_BITS(HEIGHT_BITS), .CW(CW), .RW(RW), .JW(JW)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job(job_out), .i_empty(empty), .o_pop(pop),
        .o_valid(o_out_valid), .i_stall(i_out_stall),
        .o_normal_x(o_normal_x), .o_normal_y(o_normal_y), .o_normal_z(o_normal_z),
        .o_out_col(o_out_col), .o_out_row(o_out_row), .o_last_of_run(o_last_of_run)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty) else $error("pop from empty queue");
    a_y_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_normal_y != '0)) else $error("zero y component");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> !o_out_valid) else $error("pop while result pending");
endmodule
`default_nettype wire
